### design/cgr_pkg.sv
// Shared types, widths and constants for the color gradient ramp generator.
package cgr_pkg;

    localparam int MAX_STOPS    = 4;
    localparam int MAX_SPAN     = 1024;
    localparam int STOP_REGS    = 4;
    localparam int STOP_LIM     = (MAX_STOPS < STOP_REGS) ? MAX_STOPS : STOP_REGS;

    localparam int POS_W        = 10;
    localparam int SPAN_W       = 11;
    localparam int CNT_W        = 3;
    localparam int COLOR_W      = 24;
    localparam int CH_W         = 8;
    localparam int NUM_CHANNELS = 3;
    localparam int IDX_W        = 4;
    localparam int DATA_W       = 24;

    localparam int NUM_W        = 12;   // ramp numerator, at most 1023 * 4
    localparam int DEN_W        = 11;   // ramp denominator, at most 1024
    localparam int SEG_W        = 2;
    localparam int PROD_W       = 18;   // 255 * 1024
    localparam int NUMER_W      = 19;   // 2 * 255 * 1024 + 1024
    localparam int DVS_W        = 12;   // 2 * 1024
    localparam int QBITS        = 8;

    localparam logic [COLOR_W-1:0] STOP0_RESET = 24'h00DCB4;
    localparam logic [CNT_W-1:0]   COUNT_RESET = 3'd1;
    localparam logic [SPAN_W-1:0]  SPAN_RESET  = 11'd64;

    typedef enum logic [IDX_W-1:0] {
        REG_STOP_COLOR_0 = 4'd0,
        REG_STOP_COLOR_1 = 4'd1,
        REG_STOP_COLOR_2 = 4'd2,
        REG_STOP_COLOR_3 = 4'd3,
        REG_STOP_COUNT   = 4'd4,
        REG_SMOOTH       = 4'd5,
        REG_MIRROR       = 4'd6,
        REG_AXIS_SPAN    = 4'd7
    } reg_index_t;

    // Effective (saturated) configuration seen by the datapath.
    typedef struct packed {
        logic [STOP_REGS-1:0][COLOR_W-1:0] stop_color;
        logic [CNT_W-1:0]                  stops;
        logic                              smooth;
        logic                              mirror;
        logic [SPAN_W-1:0]                 span;
    } cfg_t;

    typedef struct packed {
        logic [SEG_W-1:0] seg;
        logic [SEG_W-1:0] nb;
        logic [DEN_W-1:0] r;
        logic [DEN_W-1:0] den;
    } seg_t;

    typedef struct packed {
        logic [NUM_CHANNELS-1:0][NUMER_W-1:0] numer;
        logic [DVS_W-1:0]                     dvs;
    } blend_t;

    // Channel c of a packed color: red is 0, green 1, blue 2.
    function automatic logic [CH_W-1:0] chan(input logic [COLOR_W-1:0] color, input int c);
        return color[(NUM_CHANNELS-1-c)*CH_W +: CH_W];
    endfunction

endpackage

### design/cgr_seg.sv
// Position fold, ramp fraction and segment / remainder split (three stages).
module cgr_seg (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  cgr_pkg::cfg_t                 cfg,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [cgr_pkg::POS_W-1:0]     in_pos,
    output logic                          out_valid,
    input  logic                          out_ready,
    output cgr_pkg::seg_t                 out_data
);

    logic                         va_reg, vb_reg, vc_reg;
    logic                         en_a, en_b, en_c;

    logic [cgr_pkg::NUM_W-1:0]    num_a_reg, num_a_next;
    logic [cgr_pkg::DEN_W-1:0]    den_a_reg, den_a_next;

    logic [cgr_pkg::NUM_W-1:0]    num_b_reg, num_b_next;
    logic [cgr_pkg::DEN_W-1:0]    den_b_reg;
    logic                         q1_b_reg, q1_b_next;

    cgr_pkg::seg_t                seg_c_reg, seg_c_next;

    // stage A locals
    logic [cgr_pkg::SPAN_W-1:0]   pc, other, idx, len;
    logic [cgr_pkg::SPAN_W:0]     len_sum;

    // stage C locals
    logic                         q0;
    logic [cgr_pkg::NUM_W-1:0]    rem_c;
    logic [cgr_pkg::SEG_W-1:0]    seg;
    logic [cgr_pkg::CNT_W-1:0]    seg_p1, last;

    assign en_c     = !vc_reg || out_ready;
    assign en_b     = !vb_reg || en_c;
    assign en_a     = !va_reg || en_b;
    assign in_ready = en_a;

    // Stage A: clamp, mirror fold, numerator and denominator of the ramp fraction
    always_comb begin
        pc = ({1'b0, in_pos} >= cfg.span) ? cfg.span - 11'd1 : {1'b0, in_pos};
        other   = cfg.span - 11'd1 - pc;
        idx     = (pc < other) ? pc : other;
        len_sum = {1'b0, cfg.span} + 12'd1;
        len     = len_sum[cgr_pkg::SPAN_W:1];
        if (cfg.mirror) begin
            if (len <= 11'd1) begin
                num_a_next = '0;
                den_a_next = 11'd1;
            end else begin
                num_a_next = cgr_pkg::NUM_W'(idx * (cfg.stops - 3'd1));
                den_a_next = len - 11'd1;
            end
        end else begin
            num_a_next = cgr_pkg::NUM_W'(pc * cfg.stops);
            den_a_next = cfg.span;
        end
    end

    // Stage B: high quotient bit (quotient never exceeds three)
    always_comb begin
        q1_b_next  = num_a_reg >= {den_a_reg, 1'b0};
        num_b_next = q1_b_next ? num_a_reg - {den_a_reg, 1'b0} : num_a_reg;
    end

    // Stage C: low quotient bit, remainder, next stop
    always_comb begin
        q0     = num_b_reg >= {1'b0, den_b_reg};
        rem_c  = q0 ? num_b_reg - {1'b0, den_b_reg} : num_b_reg;
        seg    = {q1_b_reg, q0};
        seg_p1 = {1'b0, seg} + 3'd1;
        last   = cfg.stops - 3'd1;
        seg_c_next.seg = seg;
        seg_c_next.den = den_b_reg;
        seg_c_next.r   = rem_c[cgr_pkg::DEN_W-1:0];
        if (cfg.mirror) begin
            seg_c_next.nb = (seg_p1 < cfg.stops) ? seg_p1[cgr_pkg::SEG_W-1:0]
                                                 : last[cgr_pkg::SEG_W-1:0];
        end else begin
            seg_c_next.nb = (seg_p1 == cfg.stops) ? '0 : seg_p1[cgr_pkg::SEG_W-1:0];
        end
        // banded or single stop: blend of a stop with itself gives the stop
        if (!cfg.smooth || cfg.stops == 3'd1) begin
            seg_c_next.nb = seg;
            seg_c_next.r  = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            va_reg <= 1'b0;
            vb_reg <= 1'b0;
            vc_reg <= 1'b0;
        end else begin
            if (en_a) va_reg <= in_valid;
            if (en_b) vb_reg <= va_reg;
            if (en_c) vc_reg <= vb_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en_a) begin
            num_a_reg <= num_a_next;
            den_a_reg <= den_a_next;
        end
        if (en_b) begin
            num_b_reg <= num_b_next;
            den_b_reg <= den_a_reg;
            q1_b_reg  <= q1_b_next;
        end
        if (en_c) seg_c_reg <= seg_c_next;
    end

    assign out_valid = vc_reg;
    assign out_data  = seg_c_reg;

endmodule

### design/cgr_blend.sv
// Stop lookup, weighted products and rounding numerator (two stages).
module cgr_blend (
    input  logic              aclk,
    input  logic              aresetn,
    input  cgr_pkg::cfg_t     cfg,
    input  logic              in_valid,
    output logic              in_ready,
    input  cgr_pkg::seg_t     in_data,
    output logic              out_valid,
    input  logic              out_ready,
    output cgr_pkg::blend_t   out_data
);

    logic                          vd_reg, ve_reg;
    logic                          en_d, en_e;

    logic [cgr_pkg::NUM_CHANNELS-1:0][cgr_pkg::PROD_W-1:0] pa_reg, pa_next;
    logic [cgr_pkg::NUM_CHANNELS-1:0][cgr_pkg::PROD_W-1:0] pb_reg, pb_next;
    logic [cgr_pkg::DEN_W-1:0]     den_d_reg;
    cgr_pkg::blend_t               bl_reg, bl_next;

    logic [cgr_pkg::COLOR_W-1:0]   color_a, color_b;
    logic [cgr_pkg::DEN_W-1:0]     wa;
    logic [cgr_pkg::NUMER_W-1:0]   sum;

    assign en_e     = !ve_reg || out_ready;
    assign en_d     = !vd_reg || en_e;
    assign in_ready = en_d;

    // Stage D: a * (D - r) and b * r per channel
    always_comb begin
        color_a = cfg.stop_color[in_data.seg];
        color_b = cfg.stop_color[in_data.nb];
        wa      = in_data.den - in_data.r;
        for (int c = 0; c < cgr_pkg::NUM_CHANNELS; c++) begin
            pa_next[c] = cgr_pkg::PROD_W'(cgr_pkg::chan(color_a, c) * wa);
            pb_next[c] = cgr_pkg::PROD_W'(cgr_pkg::chan(color_b, c) * in_data.r);
        end
    end

    // Stage E: 2 * (sum) + D, divisor 2 * D
    always_comb begin
        sum = '0;
        for (int c = 0; c < cgr_pkg::NUM_CHANNELS; c++) begin
            sum = cgr_pkg::NUMER_W'(pa_reg[c]) + cgr_pkg::NUMER_W'(pb_reg[c]);
            bl_next.numer[c] = {sum[cgr_pkg::NUMER_W-2:0], 1'b0}
                             + cgr_pkg::NUMER_W'(den_d_reg);
        end
        bl_next.dvs = {den_d_reg, 1'b0};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vd_reg <= 1'b0;
            ve_reg <= 1'b0;
        end else begin
            if (en_d) vd_reg <= in_valid;
            if (en_e) ve_reg <= vd_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en_d) begin
            pa_reg    <= pa_next;
            pb_reg    <= pb_next;
            den_d_reg <= in_data.den;
        end
        if (en_e) bl_reg <= bl_next;
    end

    assign out_valid = ve_reg;
    assign out_data  = bl_reg;

endmodule

### design/cgr_div.sv
// Pipelined restoring divider, one quotient bit per stage, three channels.
module cgr_div (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_valid,
    output logic              in_ready,
    input  cgr_pkg::blend_t   in_data,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [cgr_pkg::NUM_CHANNELS-1:0][cgr_pkg::CH_W-1:0] out_q
);

    localparam int LAST = cgr_pkg::QBITS - 1;

    logic [cgr_pkg::QBITS-1:0] valid_reg;
    logic [cgr_pkg::QBITS-1:0] en;
    logic [cgr_pkg::QBITS-1:0][cgr_pkg::NUM_CHANNELS-1:0][cgr_pkg::NUMER_W-1:0] rem_reg;
    logic [cgr_pkg::QBITS-1:0][cgr_pkg::NUM_CHANNELS-1:0][cgr_pkg::QBITS-1:0]   q_reg;
    logic [cgr_pkg::QBITS-1:0][cgr_pkg::DVS_W-1:0]                              dvs_reg;

    assign in_ready = en[0];

    for (genvar i = 0; i < cgr_pkg::QBITS; i++) begin : g_stage
        localparam int K = cgr_pkg::QBITS - 1 - i;

        logic                                                     v_in;
        logic [cgr_pkg::DVS_W-1:0]                                dvs_in;
        logic [cgr_pkg::NUM_CHANNELS-1:0][cgr_pkg::NUMER_W-1:0]   rem_in, rem_next;
        logic [cgr_pkg::NUM_CHANNELS-1:0][cgr_pkg::QBITS-1:0]     q_in, q_next;
        logic [cgr_pkg::NUMER_W-1:0]                              trial;

        if (i == 0) begin : g_first
            assign v_in   = in_valid;
            assign dvs_in = in_data.dvs;
            assign rem_in = in_data.numer;
            assign q_in   = '0;
        end else begin : g_rest
            assign v_in   = valid_reg[i-1];
            assign dvs_in = dvs_reg[i-1];
            assign rem_in = rem_reg[i-1];
            assign q_in   = q_reg[i-1];
        end

        if (i == LAST) begin : g_en_last
            assign en[i] = !valid_reg[i] || out_ready;
        end else begin : g_en_mid
            assign en[i] = !valid_reg[i] || en[i+1];
        end

        assign trial = cgr_pkg::NUMER_W'(dvs_in) << K;

        always_comb begin
            for (int c = 0; c < cgr_pkg::NUM_CHANNELS; c++) begin
                if (rem_in[c] >= trial) begin
                    rem_next[c] = rem_in[c] - trial;
                    q_next[c]   = q_in[c] | (cgr_pkg::QBITS'(1) << K);
                end else begin
                    rem_next[c] = rem_in[c];
                    q_next[c]   = q_in[c];
                end
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                valid_reg[i] <= 1'b0;
            end else if (en[i]) begin
                valid_reg[i] <= v_in;
            end
        end

        always_ff @(posedge aclk) begin
            if (en[i]) begin
                rem_reg[i] <= rem_next;
                q_reg[i]   <= q_next;
                dvs_reg[i] <= dvs_in;
            end
        end
    end

    assign out_valid = valid_reg[LAST];
    always_comb begin
        for (int c = 0; c < cgr_pkg::NUM_CHANNELS; c++) begin
            out_q[c] = q_reg[LAST][c][cgr_pkg::CH_W-1:0];
        end
    end

endmodule

### design/color_gradient_ramp_generator.sv
// Pipeline from an accepted request to its color on m_valid: 3 fraction stages,
// 2 blend stages, 8 divider stages, one quotient bit each.
// Throughput: one request per cycle while m_ready is high; every stage has its own valid bit and
// stalls only when full and blocked downstream, so bubbles are absorbed.
// Reset (aresetn low, synchronous): pipeline emptied, registers return to
// stop 0 = 0x00DCB4, other stops 0, one stop, smooth on, mirror off, span 64.
module color_gradient_ramp_generator (
    input  logic                                aclk,
    input  logic                                aresetn,
    // configuration writes
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [cgr_pkg::IDX_W-1:0]           cfg_index,
    input  logic [cgr_pkg::DATA_W-1:0]          cfg_data,
    // position requests
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [cgr_pkg::POS_W-1:0]           s_axis_position,
    // pixel colors
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [cgr_pkg::CH_W-1:0]            m_red,
    output logic [cgr_pkg::CH_W-1:0]            m_green,
    output logic [cgr_pkg::CH_W-1:0]            m_blue
);

    // ------------------------------------------------------------------
    // Configuration registers. Writes are always taken; data is masked to
    // each register's width, indexes past the list are dropped.
    // ------------------------------------------------------------------
    logic [cgr_pkg::STOP_REGS-1:0][cgr_pkg::COLOR_W-1:0] stop_color_reg;
    logic [cgr_pkg::CNT_W-1:0]   stop_count_reg;
    logic                        smooth_reg;
    logic                        mirror_reg;
    logic [cgr_pkg::SPAN_W-1:0]  axis_span_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            // stop 0 sits in the low bits, the other stops clear
            stop_color_reg    <= (cgr_pkg::STOP_REGS*cgr_pkg::COLOR_W)'(cgr_pkg::STOP0_RESET);
            stop_count_reg    <= cgr_pkg::COUNT_RESET;
            smooth_reg        <= 1'b1;
            mirror_reg        <= 1'b0;
            axis_span_reg     <= cgr_pkg::SPAN_RESET;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                cgr_pkg::REG_STOP_COLOR_0: stop_color_reg[0] <= cfg_data[cgr_pkg::COLOR_W-1:0];
                cgr_pkg::REG_STOP_COLOR_1: stop_color_reg[1] <= cfg_data[cgr_pkg::COLOR_W-1:0];
                cgr_pkg::REG_STOP_COLOR_2: stop_color_reg[2] <= cfg_data[cgr_pkg::COLOR_W-1:0];
                cgr_pkg::REG_STOP_COLOR_3: stop_color_reg[3] <= cfg_data[cgr_pkg::COLOR_W-1:0];
                cgr_pkg::REG_STOP_COUNT:   stop_count_reg    <= cfg_data[cgr_pkg::CNT_W-1:0];
                cgr_pkg::REG_SMOOTH:       smooth_reg        <= cfg_data[0];
                cgr_pkg::REG_MIRROR:       mirror_reg        <= cfg_data[0];
                cgr_pkg::REG_AXIS_SPAN:    axis_span_reg     <= cfg_data[cgr_pkg::SPAN_W-1:0];
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Effective settings: stop count forced into 1..STOP_LIM, span into
    // 1..MAX_SPAN. Every stage reads these directly; the user must change
    // registers only while the pipe is empty, which the block does not enforce.
    // ------------------------------------------------------------------
    cgr_pkg::cfg_t cfg;

    always_comb begin
        cfg.stop_color = stop_color_reg;
        cfg.smooth     = smooth_reg;
        cfg.mirror     = mirror_reg;
        if (stop_count_reg == '0)
            cfg.stops = cgr_pkg::CNT_W'(1);
        else if (stop_count_reg > cgr_pkg::CNT_W'(cgr_pkg::STOP_LIM))
            cfg.stops = cgr_pkg::CNT_W'(cgr_pkg::STOP_LIM);
        else
            cfg.stops = stop_count_reg;
        if (axis_span_reg == '0)
            cfg.span = cgr_pkg::SPAN_W'(1);
        else if (axis_span_reg > cgr_pkg::SPAN_W'(cgr_pkg::MAX_SPAN))
            cfg.span = cgr_pkg::SPAN_W'(cgr_pkg::MAX_SPAN);
        else
            cfg.span = axis_span_reg;
    end

    // ------------------------------------------------------------------
    // Datapath: fraction f = num/den split into segment and remainder,
    // then per channel floor((2*(a*(D-r) + b*r) + D) / (2*D)).
    // Banded mode and single stop reuse the blend with b = a, r = 0.
    // ------------------------------------------------------------------
    logic            seg_valid, seg_ready;
    cgr_pkg::seg_t   seg_data;
    logic            bl_valid, bl_ready;
    cgr_pkg::blend_t bl_data;
    logic [cgr_pkg::NUM_CHANNELS-1:0][cgr_pkg::CH_W-1:0] q;

    cgr_seg u_seg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg),
        .in_valid  (s_valid),
        .in_ready  (s_ready),
        .in_pos    (s_axis_position),
        .out_valid (seg_valid),
        .out_ready (seg_ready),
        .out_data  (seg_data)
    );

    cgr_blend u_blend (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg),
        .in_valid  (seg_valid),
        .in_ready  (seg_ready),
        .in_data   (seg_data),
        .out_valid (bl_valid),
        .out_ready (bl_ready),
        .out_data  (bl_data)
    );

    // last divider stage doubles as the output register
    cgr_div u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (bl_valid),
        .in_ready  (bl_ready),
        .in_data   (bl_data),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .out_q     (q)
    );

    assign m_red   = q[0];
    assign m_green = q[1];
    assign m_blue  = q[2];

endmodule

### dv/color_gradient_ramp_generator_test.sv
// Self-checking testbench for the color gradient ramp generator.
module color_gradient_ramp_generator_test;
    import cgr_pkg::*;

    // Request to color: the sum of the stages given at the head of the block.
    localparam int LATENCY = 13;
    // An index past the last mapped register; writes to it must be ignored.
    localparam logic [IDX_W-1:0] REG_UNUSED = IDX_W'(int'(REG_AXIS_SPAN) + 2);
    localparam int PHASES_RANDOM = 14;
    localparam int REQUESTS_PER_PHASE = 125;

    // Packed so that a stop color drops straight in: red 23:16, green 15:8, blue 7:0.
    typedef struct packed {
        logic [CH_W-1:0] red;
        logic [CH_W-1:0] green;
        logic [CH_W-1:0] blue;
    } pixel_t;

    // Register shadow, color predictor and queue of colors still owed by the block.
    class ramp_color_scoreboard;
        logic [COLOR_W-1:0] stop_color [STOP_REGS];
        logic [CNT_W-1:0]   stop_count;
        logic               smooth_on;
        logic               mirror_on;
        logic [SPAN_W-1:0]  axis_span;
        pixel_t             expected_colors [$];
        int                 errors;

        function new();
            foreach (stop_color[i]) stop_color[i] = '0;
            stop_color[0] = STOP0_RESET;
            stop_count    = COUNT_RESET;
            smooth_on     = 1'b1;
            mirror_on     = 1'b0;
            axis_span     = SPAN_RESET;
            errors        = 0;
        endfunction

        function void write_reg(logic [IDX_W-1:0] index, logic [DATA_W-1:0] data);
            case (index)
                REG_STOP_COLOR_0, REG_STOP_COLOR_1,
                REG_STOP_COLOR_2, REG_STOP_COLOR_3: stop_color[index[1:0]] = data[COLOR_W-1:0];
                REG_STOP_COUNT: stop_count = data[CNT_W-1:0];
                REG_SMOOTH:     smooth_on  = data[0];
                REG_MIRROR:     mirror_on  = data[0];
                REG_AXIS_SPAN:  axis_span  = data[SPAN_W-1:0];
                default: ;
            endcase
        endfunction

        // Linear blend of a toward b by r/d, rounded half up.
        function int unsigned blend_channel(int unsigned a, int unsigned b,
                                            int unsigned r, int unsigned d);
            int unsigned v;
            v = (2 * (a * (d - r) + b * r) + d) / (2 * d);
            return (v > 255) ? 255 : v;
        endfunction

        function pixel_t predict_color(logic [POS_W-1:0] pos);
            int unsigned n, span, p, len, fold, num, den, seg, rem, nb;
            logic [COLOR_W-1:0] ca, cb;
            pixel_t px;
            n = stop_count;
            if (n < 1) n = 1;
            if (n > STOP_LIM) n = STOP_LIM;
            span = axis_span;
            if (span < 1) span = 1;
            if (span > MAX_SPAN) span = MAX_SPAN;
            p = pos;
            if (p >= span) p = span - 1;
            if (mirror_on) begin
                // fold about the center; ramp runs first to last stop, no wrap
                len  = (span + 1) / 2;
                fold = (p < span - 1 - p) ? p : span - 1 - p;
                if (len <= 1) begin
                    num = 0;
                    den = 1;
                end else begin
                    num = fold * (n - 1);
                    den = len - 1;
                end
            end else begin
                num = p * n;
                den = span;
            end
            seg = num / den;
            if (seg > n - 1) seg = n - 1;
            rem = num - seg * den;
            ca  = stop_color[seg];
            if (!smooth_on || n == 1) begin
                px = pixel_t'(ca);
            end else begin
                // cyclic in normal mode: last stop blends back into the first
                if (mirror_on) nb = (seg + 1 < n) ? seg + 1 : n - 1;
                else           nb = (seg + 1) % n;
                cb = stop_color[nb];
                px.red   = CH_W'(blend_channel(ca[23:16], cb[23:16], rem, den));
                px.green = CH_W'(blend_channel(ca[15:8], cb[15:8], rem, den));
                px.blue  = CH_W'(blend_channel(ca[7:0], cb[7:0], rem, den));
            end
            return px;
        endfunction

        function void note_position(logic [POS_W-1:0] pos);
            expected_colors = {expected_colors, predict_color(pos)};
        endfunction

        function void check_color(pixel_t got);
            pixel_t want;
            string  names [3];
            names = '{"red", "green", "blue"};
            if (expected_colors.size() == 0) begin
                errors++;
                $error("color %h with no request outstanding", got);
                return;
            end
            want = expected_colors.pop_front();
            for (int c = 0; c < NUM_CHANNELS; c++) begin
                if (got[(2 - c) * CH_W +: CH_W] !== want[(2 - c) * CH_W +: CH_W]) begin
                    errors++;
                    $error("%s: expected %0d, got %0d", names[c],
                           want[(2 - c) * CH_W +: CH_W], got[(2 - c) * CH_W +: CH_W]);
                end
            end
        endfunction

        function int pending();
            return expected_colors.size();
        endfunction
    endclass

    logic              aclk            = 1'b0;
    logic              aresetn         = 1'b0;
    logic              cfg_valid       = 1'b0;
    logic              cfg_ready;
    logic [IDX_W-1:0]  cfg_index       = '0;
    logic [DATA_W-1:0] cfg_data        = '0;
    logic              s_valid         = 1'b0;
    logic              s_ready;
    logic [POS_W-1:0]  s_axis_position = '0;
    logic              m_valid;
    logic              m_ready         = 1'b0;
    logic [CH_W-1:0]   m_red;
    logic [CH_W-1:0]   m_green;
    logic [CH_W-1:0]   m_blue;

    // Percent chance per cycle that the sender holds off / the sink stalls.
    int sender_idle_pct = 0;
    int sink_stall_pct  = 0;

    ramp_color_scoreboard ramp_model = new();
    logic [POS_W-1:0]     positions [$];

    color_gradient_ramp_generator u_dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_axis_position (s_axis_position),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_red           (m_red),
        .m_green         (m_green),
        .m_blue          (m_blue)
    );

    initial begin
        forever #6 aclk = ~aclk;
    end

    // Sink side: values sampled here are the pre-edge ones, so the handshake
    // seen is exactly the one the block saw. Ready is re-rolled every cycle.
    always @(posedge aclk) begin
        if (m_valid && m_ready)
            ramp_model.check_color({m_red, m_green, m_blue});
        m_ready <= ($urandom_range(99) >= sink_stall_pct);
    end

    // Hard stop in case the pipeline locks up.
    initial begin
        #5000000;
        $display("[color_gradient_ramp_generator] ERROR");
        $finish;
    end

    // Register write; cfg_valid stays up so back-to-back writes need no toggle.
    task automatic write_reg(input logic [IDX_W-1:0] index, input logic [DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data  <= data;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        ramp_model.write_reg(index, data);
    endtask

    // One position request. Idle cycles are inserted before valid goes up,
    // never while a request is pending.
    task automatic send_position(input logic [POS_W-1:0] pos);
        while ($urandom_range(99) < sender_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid         <= 1'b1;
        s_axis_position <= pos;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        ramp_model.note_position(pos);
    endtask

    // Sends the queued positions under one idling mode, then drains the
    // pipeline so the next register writes land on an idle block.
    task automatic run_phase(input int mode);
        cfg_valid <= 1'b0;
        case (mode % 4)
            0: begin sender_idle_pct = 0;  sink_stall_pct = 0;  end
            1: begin sender_idle_pct = 45; sink_stall_pct = 0;  end
            2: begin sender_idle_pct = 0;  sink_stall_pct = 45; end
            default: begin sender_idle_pct = 6; sink_stall_pct = 6; end
        endcase
        foreach (positions[i]) send_position(positions[i]);
        s_valid <= 1'b0;
        positions.delete();
        while (ramp_model.pending() != 0) @(posedge aclk);
        repeat (LATENCY + 4) @(posedge aclk);
    endtask

    // Random settings for one phase; returns the span as the block will use it.
    task automatic randomize_config(output int eff_span);
        logic [DATA_W-1:0] span_raw;
        logic [DATA_W-1:0] count_raw;
        for (int i = 0; i < STOP_REGS; i++) begin
            case ($urandom_range(7))
                0:       write_reg(IDX_W'(int'(REG_STOP_COLOR_0) + i), 24'h000000);
                1:       write_reg(IDX_W'(int'(REG_STOP_COLOR_0) + i), 24'hFFFFFF);
                default: write_reg(IDX_W'(int'(REG_STOP_COLOR_0) + i), DATA_W'($urandom));
            endcase
        end
        case ($urandom_range(9))
            0:       count_raw = '0;                               // read as one stop
            1:       count_raw = DATA_W'($urandom_range(5, 7));    // saturates at four
            default: count_raw = DATA_W'($urandom_range(1, STOP_LIM));
        endcase
        write_reg(REG_STOP_COUNT, count_raw);
        write_reg(REG_SMOOTH, DATA_W'($urandom));
        write_reg(REG_MIRROR, DATA_W'($urandom));
        case ($urandom_range(9))
            0:       span_raw = DATA_W'(1);
            1:       span_raw = DATA_W'(2);
            2:       span_raw = DATA_W'(MAX_SPAN);
            3:       span_raw = DATA_W'($urandom_range(MAX_SPAN + 1, 2047));
            4:       span_raw = '0;
            5, 6:    span_raw = DATA_W'($urandom_range(1, MAX_SPAN));
            default: span_raw = DATA_W'($urandom_range(3, 64));
        endcase
        write_reg(REG_AXIS_SPAN, span_raw);
        // now and then a write to an unmapped index, which must change nothing
        if ($urandom_range(3) == 0)
            write_reg(IDX_W'($urandom_range(int'(REG_AXIS_SPAN) + 1, 2**IDX_W - 1)),
                      DATA_W'($urandom));
        eff_span = (span_raw == 0) ? 1 : (span_raw > MAX_SPAN) ? MAX_SPAN : int'(span_raw);
    endtask

    initial begin
        int eff_span;
        logic [POS_W-1:0] pick;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Reset settings: single stop, so every position gives stop 0;
        // 64 and 1023 are past the span and clamp.
        positions = '{0, 63, 64, 1023};
        run_phase(0);

        // Three primaries and white, full span, cyclic blend including the wrap
        // from the last stop back to the first.
        write_reg(REG_STOP_COLOR_0, 24'hFF0000);
        write_reg(REG_STOP_COLOR_1, 24'h00FF00);
        write_reg(REG_STOP_COLOR_2, 24'h0000FF);
        write_reg(REG_STOP_COLOR_3, 24'hFFFFFF);
        write_reg(REG_STOP_COUNT, 24'd4);
        write_reg(REG_AXIS_SPAN, DATA_W'(MAX_SPAN));
        positions = '{0, 128, 255, 256, 511, 1023};
        run_phase(1);

        // Mirror on an odd span: three stops folded about the center.
        write_reg(REG_MIRROR, 24'd1);
        write_reg(REG_STOP_COUNT, 24'd3);
        write_reg(REG_AXIS_SPAN, 24'd7);
        positions = '{0, 2, 3, 6};
        run_phase(2);

        // Hard bands; count and span above range saturate; unmapped write ignored.
        write_reg(REG_SMOOTH, 24'd0);
        write_reg(REG_MIRROR, 24'd0);
        write_reg(REG_STOP_COUNT, 24'd7);
        write_reg(REG_AXIS_SPAN, 24'd2047);
        write_reg(REG_UNUSED, 24'hFFFFFF);
        positions = '{300, 1023};
        run_phase(3);

        // Zero stop count and zero span both read as one.
        write_reg(REG_SMOOTH, 24'd1);
        write_reg(REG_MIRROR, 24'd1);
        write_reg(REG_STOP_COUNT, 24'd0);
        write_reg(REG_AXIS_SPAN, 24'd0);
        positions = '{0, 5};
        run_phase(0);

        // Mirror with a ramp length of one: fraction forced to zero.
        write_reg(REG_STOP_COUNT, 24'd4);
        write_reg(REG_AXIS_SPAN, 24'd2);
        positions = '{0, 1};
        run_phase(1);

        // Black to white mirrored over the full span, center and quarter.
        write_reg(REG_STOP_COLOR_0, 24'h000000);
        write_reg(REG_STOP_COLOR_1, 24'hFFFFFF);
        write_reg(REG_STOP_COUNT, 24'd2);
        write_reg(REG_AXIS_SPAN, DATA_W'(MAX_SPAN));
        positions = '{256, 511, 512};
        run_phase(2);

        // Random phases: settings change between phases, positions mostly
        // inside the span, some on its edges and some anywhere.
        for (int ph = 0; ph < PHASES_RANDOM; ph++) begin
            randomize_config(eff_span);
            for (int k = 0; k < REQUESTS_PER_PHASE; k++) begin
                case ($urandom_range(19))
                    0:       pick = '0;
                    1:       pick = POS_W'(eff_span - 1);
                    2:       pick = POS_W'(eff_span);
                    3:       pick = '1;
                    4, 5, 6, 7, 8, 9, 10:
                             pick = POS_W'($urandom);
                    default: pick = POS_W'($urandom_range(0, eff_span - 1));
                endcase
                positions = {positions, pick};
            end
            run_phase(ph);
        end

        if (ramp_model.errors == 0 && ramp_model.pending() == 0)
            $display("[color_gradient_ramp_generator] OK");
        else
            $display("[color_gradient_ramp_generator] ERROR");
        $finish;
    end

endmodule
